// File: src/pld_pkg.sv
// ============================================================================
// pld_pkg: shared types and constants of the PI position loop
// Field widths, register indexes and reset values, and the serial unit widths.
// ============================================================================
package pld_pkg;

    localparam int CMD_W      = 8;
    localparam int ENC_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int POS_W      = 15;
    localparam int OFS_W      = 12;
    localparam int DRV_W      = 12;
    localparam int ERR_W      = 16;
    localparam int INTEG_W    = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Shift-add multiplier: one 4-bit digit of the B operand per cycle
    localparam int MUL_A_W     = 17;
    localparam int MUL_B_W     = 16;
    localparam int MUL_DIGIT_W = 4;
    localparam int MUL_STEPS   = MUL_B_W / MUL_DIGIT_W;
    localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

    // Bit-serial divide by one hundred
    localparam int DIV_W     = 22;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int DIV_REM_W = 7;
    localparam logic [DIV_REM_W:0] DIVISOR = 8'd100;

    localparam logic signed [CMD_W-1:0] CMD_MAX = 8'sd100;
    localparam logic signed [CMD_W-1:0] CMD_MIN = -8'sd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN    = 3'd0,
        CFG_INTEG_GAIN   = 3'd1,
        CFG_DEADBAND     = 3'd2,
        CFG_DRIVE_OFFSET = 3'd3,
        CFG_CENTRE_POS   = 3'd4,
        CFG_FULL_POS     = 3'd5
    } cfg_reg_t;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST    = 16'd42598;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST   = 16'd983;
    localparam logic [POS_W-1:0]  DEADBAND_RST     = 15'd120;
    localparam logic [OFS_W-1:0]  DRIVE_OFFSET_RST = 12'd1250;
    localparam logic [POS_W-1:0]  CENTRE_POS_RST   = 15'd580;
    localparam logic [POS_W-1:0]  FULL_POS_RST     = 15'd1300;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

// File: src/pld_channels.sv
// ============================================================================
// pld channels: valid/ready stream interfaces of the position loop
// One channel carries a control tick in, the other the drive result out.
// ============================================================================
interface pld_tick_if;
    logic                                valid;
    logic                                ready;
    logic signed [pld_pkg::CMD_W-1:0]    command;
    logic signed [pld_pkg::ENC_W-1:0]    encoder_count;

    modport source (output valid, output command, output encoder_count, input ready);
    modport sink   (input valid, input command, input encoder_count, output ready);
endinterface

interface pld_result_if;
    logic                            valid;
    logic                            ready;
    logic [pld_pkg::DRV_W-1:0]       drive_level;
    logic                            move_right;

    modport source (output valid, output drive_level, output move_right, input ready);
    modport sink   (input valid, input drive_level, input move_right, output ready);
endinterface

// File: src/pld_serial_mul.sv
// ============================================================================
// pld_serial_mul: digit-serial unsigned multiplier
// Consumes the B operand one 4-bit digit per cycle, most significant first.
// ============================================================================
module pld_serial_mul (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [pld_pkg::MUL_A_W-1:0]    a,
    input  logic [pld_pkg::MUL_B_W-1:0]    b,
    output pld_pkg::unit_status_t          status,
    output logic [pld_pkg::MUL_P_W-1:0]    product
);

    logic [pld_pkg::MUL_A_W-1:0]                       a_reg;
    logic [pld_pkg::MUL_B_W-1:0]                       b_reg;
    logic [pld_pkg::MUL_B_W-1:0]                       b_next;
    logic [pld_pkg::MUL_P_W-1:0]                       acc_reg;
    logic [pld_pkg::MUL_P_W-1:0]                       acc_next;
    logic [pld_pkg::MUL_CNT_W-1:0]                     cnt_reg;
    logic [pld_pkg::MUL_CNT_W-1:0]                     cnt_next;
    logic                                              run_reg;
    logic                                              run_next;
    logic                                              done_reg;
    logic                                              done_next;
    logic [pld_pkg::MUL_A_W+pld_pkg::MUL_DIGIT_W-1:0]  partial;

    // one digit product per cycle, accumulated Horner style
    always_comb
    begin
        partial  = a_reg * b_reg[pld_pkg::MUL_B_W-1 -: pld_pkg::MUL_DIGIT_W];
        acc_next = {acc_reg[pld_pkg::MUL_P_W-pld_pkg::MUL_DIGIT_W-1:0],
                    {pld_pkg::MUL_DIGIT_W{1'b0}}}
                 + pld_pkg::MUL_P_W'(partial);
        b_next   = {b_reg[pld_pkg::MUL_B_W-pld_pkg::MUL_DIGIT_W-1:0],
                    {pld_pkg::MUL_DIGIT_W{1'b0}}};
    end

    always_comb
    begin
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == pld_pkg::MUL_CNT_W'(pld_pkg::MUL_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            b_reg   <= b_next;
            acc_reg <= acc_next;
        end
    end

    assign status.busy = run_reg;
    assign status.done = done_reg;
    assign product     = acc_reg;

endmodule

// File: src/pld_div100.sv
// ============================================================================
// pld_div100: bit-serial divide by one hundred
// Restoring long division, one quotient bit per cycle, narrow remainder.
// ============================================================================
module pld_div100 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pld_pkg::DIV_W-1:0]     dividend,
    output pld_pkg::unit_status_t         status,
    output logic [pld_pkg::DIV_W-1:0]     quotient
);

    logic [pld_pkg::DIV_W-1:0]      dvd_reg;
    logic [pld_pkg::DIV_W-1:0]      quo_reg;
    logic [pld_pkg::DIV_REM_W-1:0]  rem_reg;
    logic [pld_pkg::DIV_REM_W-1:0]  rem_next;
    logic [pld_pkg::DIV_REM_W:0]    trial;
    logic [pld_pkg::DIV_REM_W:0]    diff;
    logic                           fits;
    logic [pld_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [pld_pkg::DIV_CNT_W-1:0]  cnt_next;
    logic                           run_reg;
    logic                           run_next;
    logic                           done_reg;
    logic                           done_next;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[pld_pkg::DIV_W-1]};
        fits     = (trial >= pld_pkg::DIVISOR);
        diff     = trial - pld_pkg::DIVISOR;
        rem_next = fits ? diff[pld_pkg::DIV_REM_W-1:0] : trial[pld_pkg::DIV_REM_W-1:0];
    end

    always_comb
    begin
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == pld_pkg::DIV_CNT_W'(pld_pkg::DIV_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg <= {dvd_reg[pld_pkg::DIV_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[pld_pkg::DIV_W-2:0], fits};
        end
    end

    assign status.busy = run_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

// File: src/pi_position_loop_deadband.sv
// ============================================================================
// pi_position_loop_deadband: PI position loop with deadband
// Maps a joystick command to a setpoint and drives a motor DAC from the error.
// ============================================================================
// Each tick transaction carries a signed joystick command and an encoder count.
// The command is clamped to -100..100 and mapped onto 0..centre (negative) or
// centre..full (positive); the error is setpoint minus encoder. The block
// returns one result transaction per tick: drive_level is floor(prop_gain *
// |error|) plus a trapezoidal integrator plus drive_offset, clamped to
// 0..4095 and forced to zero when |error| <= deadband; move_right is set when
// the error is negative. A tick with a negative encoder count is taken and
// dropped with no result and no state change. Gains are unsigned Q0.16. A tick
// with a valid encoder occupies the block through three passes through the
// shared 4-bit-per-cycle multiplier plus the 22-step bit-serial divide by 100
// for the setpoint mapping. A finished result waits in the output register
// while the next tick is accepted. Registers are to be written through
// cfg_wen/cfg_addr/cfg_data only while idle; the block does not enforce this;
// writes to indexes above five are ignored.
module pi_position_loop_deadband (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [pld_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [pld_pkg::CFG_DATA_W-1:0]    cfg_data,
    pld_tick_if.sink                          tick,
    pld_result_if.source                      result
);

    // one-hot sequencer states
    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_MAP_MUL  = 7'b0000010,
        ST_MAP_DIV  = 7'b0000100,
        ST_ERR      = 7'b0001000,
        ST_PROP_MUL = 7'b0010000,
        ST_INT_MUL  = 7'b0100000,
        ST_EMIT     = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // configuration registers
    logic [pld_pkg::GAIN_W-1:0] prop_gain_reg;
    logic [pld_pkg::GAIN_W-1:0] integ_gain_reg;
    logic [pld_pkg::POS_W-1:0]  deadband_reg;
    logic [pld_pkg::OFS_W-1:0]  drive_offset_reg;
    logic [pld_pkg::POS_W-1:0]  centre_reg;
    logic [pld_pkg::POS_W-1:0]  full_reg;

    // loop state
    logic [pld_pkg::ERR_W-1:0]   last_error_reg;
    logic [pld_pkg::INTEG_W-1:0] integral_sum_reg;
    logic [pld_pkg::INTEG_W-1:0] integral_sum_next;

    // per-tick working registers
    logic                        sub_reg;
    logic [pld_pkg::POS_W-1:0]   enc_reg;
    logic [pld_pkg::ERR_W-1:0]   err_reg;
    logic [pld_pkg::ERR_W-1:0]   err_next;
    logic [pld_pkg::POS_W-1:0]   mag_reg;
    logic [pld_pkg::POS_W-1:0]   mag_next;
    logic [pld_pkg::POS_W-1:0]   prop_reg;
    logic                        sum_neg_reg;

    // output register
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [pld_pkg::DRV_W-1:0]   drive_reg;
    logic [pld_pkg::DRV_W-1:0]   drive_next;
    logic                        right_reg;
    logic                        out_free;

    // serial units
    logic                          mul_start;
    logic [pld_pkg::MUL_A_W-1:0]   mul_a;
    logic [pld_pkg::MUL_B_W-1:0]   mul_b;
    logic [pld_pkg::MUL_P_W-1:0]   mul_product;
    pld_pkg::unit_status_t         mul_status;
    logic                          div_start;
    logic [pld_pkg::DIV_W-1:0]     div_quotient;
    pld_pkg::unit_status_t         div_status;

    // tick decode
    logic                               accept;
    logic                               enc_neg;
    logic signed [pld_pkg::CMD_W-1:0]   cmd_clamped;
    logic [pld_pkg::CMD_W-1:0]          cmd_abs;
    logic                               cmd_neg;
    logic [pld_pkg::POS_W:0]            span;
    logic [pld_pkg::POS_W:0]            span_abs;
    logic                               span_neg;

    // setpoint and error
    logic [pld_pkg::POS_W+1:0]   setpoint;
    logic [pld_pkg::POS_W+1:0]   err_wide;
    logic [pld_pkg::ERR_W-1:0]   err_abs;

    // integrator
    logic [pld_pkg::ERR_W:0]     err_sum;
    logic [pld_pkg::ERR_W:0]     err_sum_abs;
    logic [34:0]                 prod_ext;
    logic [34:0]                 prod_signed;
    logic [34:0]                 integ_acc;
    logic [17:0]                 integ_trunc;

    // drive
    logic [17:0]                 drive_sum;

    assign accept      = tick.valid && tick.ready;
    assign tick.ready  = (state_reg == ST_IDLE);
    assign enc_neg     = tick.encoder_count[pld_pkg::ENC_W-1];
    assign out_free    = !out_valid_reg || result.ready;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg    <= pld_pkg::PROP_GAIN_RST;
            integ_gain_reg   <= pld_pkg::INTEG_GAIN_RST;
            deadband_reg     <= pld_pkg::DEADBAND_RST;
            drive_offset_reg <= pld_pkg::DRIVE_OFFSET_RST;
            centre_reg       <= pld_pkg::CENTRE_POS_RST;
            full_reg         <= pld_pkg::FULL_POS_RST;
        end
        else if (cfg_wen)
        begin
            unique case (pld_pkg::cfg_reg_t'(cfg_addr))
                pld_pkg::CFG_PROP_GAIN:    prop_gain_reg    <= cfg_data;
                pld_pkg::CFG_INTEG_GAIN:   integ_gain_reg   <= cfg_data;
                pld_pkg::CFG_DEADBAND:     deadband_reg     <= cfg_data[pld_pkg::POS_W-1:0];
                pld_pkg::CFG_DRIVE_OFFSET: drive_offset_reg <= cfg_data[pld_pkg::OFS_W-1:0];
                pld_pkg::CFG_CENTRE_POS:   centre_reg       <= cfg_data[pld_pkg::POS_W-1:0];
                pld_pkg::CFG_FULL_POS:     full_reg         <= cfg_data[pld_pkg::POS_W-1:0];
                default:                   ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Command clamp and mapping operands
    // ------------------------------------------------------------------
    always_comb
    begin
        if (tick.command > pld_pkg::CMD_MAX)
            cmd_clamped = pld_pkg::CMD_MAX;
        else if (tick.command < pld_pkg::CMD_MIN)
            cmd_clamped = pld_pkg::CMD_MIN;
        else
            cmd_clamped = tick.command;
        cmd_neg  = cmd_clamped[pld_pkg::CMD_W-1];
        cmd_abs  = cmd_neg ? (-cmd_clamped) : cmd_clamped;
        // span = full - centre, taken as sign and magnitude
        span     = {1'b0, full_reg} - {1'b0, centre_reg};
        span_neg = span[pld_pkg::POS_W];
        span_abs = span_neg ? (-span) : span;
    end

    // ------------------------------------------------------------------
    // Setpoint, error and magnitude
    // ------------------------------------------------------------------
    always_comb
    begin
        // a negative command or a falling span pulls the setpoint below centre
        if (sub_reg)
            setpoint = {2'b00, centre_reg} - {2'b00, div_quotient[pld_pkg::POS_W-1:0]};
        else
            setpoint = {2'b00, centre_reg} + {2'b00, div_quotient[pld_pkg::POS_W-1:0]};
        err_wide = setpoint - {2'b00, enc_reg};
        err_next = err_wide[pld_pkg::ERR_W-1:0];
        err_abs  = err_next[pld_pkg::ERR_W-1] ? (-err_next) : err_next;
        mag_next = err_abs[pld_pkg::POS_W-1:0];
    end

    // ------------------------------------------------------------------
    // Trapezoidal integrator, exact in Q.17, truncated toward zero
    // ------------------------------------------------------------------
    always_comb
    begin
        err_sum     = {err_reg[pld_pkg::ERR_W-1], err_reg}
                    + {last_error_reg[pld_pkg::ERR_W-1], last_error_reg};
        err_sum_abs = err_sum[pld_pkg::ERR_W] ? (-err_sum) : err_sum;
        prod_ext    = {2'b00, mul_product};
        prod_signed = sum_neg_reg ? (-prod_ext) : prod_ext;
        integ_acc   = {{2{integral_sum_reg[pld_pkg::INTEG_W-1]}}, integral_sum_reg, 17'd0}
                    + prod_signed;
        // floor shift, then step up by one for a negative value with a fraction
        integ_trunc = integ_acc[34:17]
                    + 18'((integ_acc[34] && (integ_acc[16:0] != 17'd0)) ? 1 : 0);
        if (integ_trunc[17:15] == 3'b000 || integ_trunc[17:15] == 3'b111)
            integral_sum_next = integ_trunc[15:0];
        else if (integ_trunc[17])
            integral_sum_next = 16'h8000;
        else
            integral_sum_next = 16'h7FFF;
    end

    // ------------------------------------------------------------------
    // Drive level: sum, saturate, deadband
    // ------------------------------------------------------------------
    always_comb
    begin
        drive_sum = {3'b000, prop_reg}
                  + {{2{integral_sum_reg[pld_pkg::INTEG_W-1]}}, integral_sum_reg}
                  + {6'd0, drive_offset_reg};
        if (mag_reg <= deadband_reg)
            drive_next = '0;
        else if (drive_sum[17])
            drive_next = '0;
        else if (drive_sum[16:12] != 5'd0)
            drive_next = '1;
        else
            drive_next = drive_sum[11:0];
    end

    // ------------------------------------------------------------------
    // Sequencer and shared multiplier issue
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // drop ticks with a negative encoder count outright
                if (accept && !enc_neg)
                begin
                    mul_start  = 1'b1;
                    mul_a      = cmd_neg ? pld_pkg::MUL_A_W'(centre_reg)
                                         : pld_pkg::MUL_A_W'(span_abs);
                    mul_b      = pld_pkg::MUL_B_W'(cmd_abs);
                    state_next = ST_MAP_MUL;
                end
            end
            ST_MAP_MUL:
            begin
                if (mul_status.done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_MAP_DIV;
                end
            end
            ST_MAP_DIV:
            begin
                if (div_status.done)
                    state_next = ST_ERR;
            end
            ST_ERR:
            begin
                mul_start  = 1'b1;
                mul_a      = pld_pkg::MUL_A_W'(mag_next);
                mul_b      = prop_gain_reg;
                state_next = ST_PROP_MUL;
            end
            ST_PROP_MUL:
            begin
                if (mul_status.done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = err_sum_abs;
                    mul_b      = integ_gain_reg;
                    state_next = ST_INT_MUL;
                end
            end
            ST_INT_MUL:
            begin
                if (mul_status.done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (state_reg == ST_EMIT && out_free)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            last_error_reg   <= '0;
            integral_sum_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            // commit loop state once the integrator product is in
            if (state_reg == ST_INT_MUL && mul_status.done)
            begin
                last_error_reg   <= err_reg;
                integral_sum_reg <= integral_sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept)
        begin
            sub_reg <= cmd_neg || span_neg;
            enc_reg <= tick.encoder_count[pld_pkg::POS_W-1:0];
        end
        if (state_reg == ST_ERR)
        begin
            err_reg <= err_next;
            mag_reg <= mag_next;
        end
        if (state_reg == ST_PROP_MUL && mul_status.done)
        begin
            prop_reg    <= mul_product[pld_pkg::GAIN_W +: pld_pkg::POS_W];
            sum_neg_reg <= err_sum[pld_pkg::ERR_W];
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            drive_reg <= drive_next;
            right_reg <= err_reg[pld_pkg::ERR_W-1];
        end
    end

    // ------------------------------------------------------------------
    // Serial arithmetic units
    // ------------------------------------------------------------------
    pld_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .status  (mul_status),
        .product (mul_product)
    );

    pld_div100 u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_product[pld_pkg::DIV_W-1:0]),
        .status   (div_status),
        .quotient (div_quotient)
    );

    assign result.valid       = out_valid_reg;
    assign result.drive_level = drive_reg;
    assign result.move_right  = right_reg;

`ifndef SYNTHESIS
    // a finished tick always lands in the output register and frees the block
    a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("emit did not load the output register");

    // multiplier and divider never run at the same time
    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_status.busy && div_status.busy))
        else $error("multiplier and divider busy together");

    // loop state moves only at the integrator commit
    a_state_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(integral_sum_reg) |-> $past(state_reg == ST_INT_MUL && mul_status.done))
        else $error("integrator changed outside its commit");

    // a tick with a negative encoder is dropped
    a_drop_negative: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && enc_neg) |=> (state_reg == ST_IDLE && !mul_status.busy))
        else $error("negative encoder tick was not dropped");
`endif

endmodule

// File: tb/pi_position_loop_deadband_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// pi_position_loop_deadband_tb: self-checking bench for the PI position loop
// Drives control ticks and register writes, predicts drive level and direction
// from an internal model of the loop, and checks every result in order.
// ============================================================================
module pi_position_loop_deadband_tb;

    // Indexes past the last register; writes there must leave every setting alone
    localparam logic [pld_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [pld_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    // Margin for a full tick to finish before the bench touches registers
    localparam int DRAIN_CYCLES   = 60;
    // Worst quiet stretch: block latency plus longest gap plus longest stall plus drain
    localparam int STALL_LIMIT    = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PHASES  = 12;
    localparam int TICKS_PER_PHASE = 84;

    typedef struct packed {
        logic signed [pld_pkg::CMD_W-1:0] command;
        logic signed [pld_pkg::ENC_W-1:0] encoder_count;
    } tick_t;

    typedef struct packed {
        logic [pld_pkg::DRV_W-1:0] drive_level;
        logic                      move_right;
    } drive_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_wen;
    logic [pld_pkg::CFG_IDX_W-1:0]  cfg_addr;
    logic [pld_pkg::CFG_DATA_W-1:0] cfg_data;

    pld_tick_if   tick_ch ();
    pld_result_if result_ch ();

    pi_position_loop_deadband u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wen  (cfg_wen),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .tick     (tick_ch),
        .result   (result_ch)
    );

    // ------------------------------------------------------------------------
    // Loop model: register copies and controller state
    // ------------------------------------------------------------------------
    logic [pld_pkg::GAIN_W-1:0]         kp_gain;
    logic [pld_pkg::GAIN_W-1:0]         ki_gain;
    logic [pld_pkg::POS_W-1:0]          deadband_lim;
    logic [pld_pkg::OFS_W-1:0]          offset_lvl;
    logic [pld_pkg::POS_W-1:0]          centre_pos;
    logic [pld_pkg::POS_W-1:0]          full_pos;
    logic signed [pld_pkg::ERR_W-1:0]   err_hist;
    logic signed [pld_pkg::INTEG_W-1:0] integ_acc;

    // Drive results still owed by the block, oldest first
    drive_t pending_drives[$];

    int  mismatch_count = 0;
    int  idle_cycles = 0;
    bit  tx_idle_on;

    // ------------------------------------------------------------------------
    // Clock: 2 ns period
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Map a command onto the setpoint under the current register values
    function automatic int command_setpoint(input logic signed [pld_pkg::CMD_W-1:0] cmd_in);
        int cmd;
        int span;
        cmd = int'(cmd_in);
        if (cmd > 100)
            cmd = 100;
        if (cmd < -100)
            cmd = -100;
        if (cmd < 0)
            return int'(centre_pos) - ((-cmd) * int'(centre_pos)) / 100;
        span = int'(full_pos) - int'(centre_pos);
        // signed division truncates toward zero, also when full sits below centre
        return int'(centre_pos) + (cmd * span) / 100;
    endfunction

    // Advance the controller by one tick; return 0 when the tick is skipped
    function automatic bit predict_drive(input tick_t t, output drive_t r);
        int     enc;
        int     err;
        int     mag;
        int     prop;
        int     integ;
        int     drv;
        longint acc;
        r = '0;
        enc = int'(t.encoder_count);
        if (enc < 0)
            return 1'b0;
        err = command_setpoint(t.command) - enc;
        mag = (err < 0) ? -err : err;
        prop = int'((longint'(mag) * longint'(kp_gain)) >>> 16);
        // trapezoidal step held exactly in Q.17, then truncated toward zero
        acc = longint'(integ_acc) * 131072
            + longint'(ki_gain) * longint'(err + int'(err_hist));
        acc = acc / 131072;
        if (acc > 32767)
            acc = 32767;
        if (acc < -32768)
            acc = -32768;
        integ = int'(acc);
        drv = prop + integ + int'(offset_lvl);
        if (drv < 0)
            drv = 0;
        if (drv > 4095)
            drv = 4095;
        if (mag <= int'(deadband_lim))
            drv = 0;
        err_hist = err[pld_pkg::ERR_W-1:0];
        integ_acc = integ[pld_pkg::INTEG_W-1:0];
        r.drive_level = drv[pld_pkg::DRV_W-1:0];
        r.move_right = (err < 0);
        return 1'b1;
    endfunction

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap(input bit enable);
        int sel;
        if (!enable)
            return 0;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return 0;
        if (sel < 85)
            return $urandom_range(1, 3);
        if (sel < 97)
            return $urandom_range(4, 12);
        return $urandom_range(13, 45);
    endfunction

    function automatic tick_t make_tick(input int cmd, input int enc);
        tick_t t;
        t.command = pld_pkg::CMD_W'(cmd);
        t.encoder_count = pld_pkg::ENC_W'(enc);
        return t;
    endfunction

    // Mostly live ticks, many of them close to the setpoint so the deadband edge
    // and sign changes get exercised; a tenth are skipped ticks.
    function automatic tick_t random_tick();
        tick_t t;
        int    enc;
        int    db;
        if ($urandom_range(0, 9) < 7)
            t.command = pld_pkg::CMD_W'(int'($urandom_range(0, 200)) - 100);
        else
            t.command = pld_pkg::CMD_W'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0)
            enc = -1 - int'($urandom_range(0, 32767));
        else if ($urandom_range(0, 9) < 4)
        begin
            db = int'(deadband_lim);
            enc = command_setpoint(t.command) + int'($urandom_range(0, 2 * db + 8)) - (db + 4);
            if (enc < 0)
                enc = 0;
            if (enc > 32767)
                enc = 32767;
        end
        else
            enc = $urandom_range(0, 32767);
        t.encoder_count = pld_pkg::ENC_W'(enc);
        return t;
    endfunction

    // Register value: zero, all ones, or random up to a typical bound; junk above
    // the register width checks that the block drops the unused data bits
    function automatic logic [pld_pkg::CFG_DATA_W-1:0] pick_reg_value(input int width,
                                                                      input int typical_max);
        logic [pld_pkg::CFG_DATA_W-1:0] mask;
        logic [pld_pkg::CFG_DATA_W-1:0] junk;
        int                             val;
        int                             sel;
        mask = pld_pkg::CFG_DATA_W'((1 << width) - 1);
        junk = pld_pkg::CFG_DATA_W'($urandom_range(0, 65535));
        sel = $urandom_range(0, 9);
        if (sel == 0)
            val = 0;
        else if (sel == 1)
            val = (1 << width) - 1;
        else
            val = $urandom_range(0, typical_max);
        return (junk & ~mask) | (pld_pkg::CFG_DATA_W'(val) & mask);
    endfunction

    // ------------------------------------------------------------------------
    // Shared drivers; all called on a falling edge and return on one
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [pld_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pld_pkg::CFG_DATA_W-1:0] data);
        cfg_wen = 1'b1;
        cfg_addr = idx;
        cfg_data = data;
        case (idx)
            pld_pkg::CFG_PROP_GAIN:    kp_gain = data[pld_pkg::GAIN_W-1:0];
            pld_pkg::CFG_INTEG_GAIN:   ki_gain = data[pld_pkg::GAIN_W-1:0];
            pld_pkg::CFG_DEADBAND:     deadband_lim = data[pld_pkg::POS_W-1:0];
            pld_pkg::CFG_DRIVE_OFFSET: offset_lvl = data[pld_pkg::OFS_W-1:0];
            pld_pkg::CFG_CENTRE_POS:   centre_pos = data[pld_pkg::POS_W-1:0];
            pld_pkg::CFG_FULL_POS:     full_pos = data[pld_pkg::POS_W-1:0];
            default:                   ;
        endcase
        @(negedge clk);
        cfg_wen = 1'b0;
    endtask

    // Send one tick; hold it until taken, then predict its result
    task automatic send_tick(input tick_t t);
        drive_t r;
        int     gap;
        gap = pick_gap(tx_idle_on);
        if (gap > 0)
        begin
            tick_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        tick_ch.command = t.command;
        tick_ch.encoder_count = t.encoder_count;
        tick_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (tick_ch.ready !== 1'b1);
        if (predict_drive(t, r))
            pending_drives.push_back(r);
        @(negedge clk);
    endtask

    // Drop valid, let every owed result drain, then give the block time to settle
    task automatic wait_idle();
        tick_ch.valid = 1'b0;
        while (pending_drives.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values: clamping, both mapping branches, deadband edges, skipped ticks
    task automatic test_reset_defaults();
        tx_idle_on = 1'b1;
        send_tick(make_tick(0, 580));       // zero error
        send_tick(make_tick(0, 460));       // error exactly at the deadband
        send_tick(make_tick(0, 459));       // one past the deadband
        send_tick(make_tick(0, 700));       // negative error at the deadband
        send_tick(make_tick(0, 701));
        send_tick(make_tick(127, 0));       // clamp high
        send_tick(make_tick(101, 32767));
        send_tick(make_tick(100, 0));
        send_tick(make_tick(-128, 0));      // clamp low
        send_tick(make_tick(-101, 32767));
        send_tick(make_tick(-1, 580));
        send_tick(make_tick(1, 580));
        send_tick(make_tick(0, -1));        // skipped, state must hold
        send_tick(make_tick(-50, -32768));  // skipped
        send_tick(make_tick(37, 1000));
        wait_idle();
    endtask

    // Register extremes: saturating integrator both ways, drive clamps,
    // full below centre, zero deadband, maximal deadband, ignored indexes
    task automatic test_register_extremes();
        write_reg(pld_pkg::CFG_PROP_GAIN, 16'hFFFF);
        write_reg(pld_pkg::CFG_INTEG_GAIN, 16'hFFFF);
        write_reg(pld_pkg::CFG_DEADBAND, 16'h0000);
        write_reg(pld_pkg::CFG_DRIVE_OFFSET, 16'hFFFF);
        write_reg(pld_pkg::CFG_CENTRE_POS, 16'h7FFF);
        write_reg(pld_pkg::CFG_FULL_POS, 16'h0000);
        send_tick(make_tick(100, 32767));   // full below centre, large negative error
        send_tick(make_tick(100, 32767));
        send_tick(make_tick(-100, 32767));  // integrator pinned low
        send_tick(make_tick(0, 0));         // swing to large positive error
        send_tick(make_tick(0, 0));
        send_tick(make_tick(0, 0));         // integrator pinned high, drive clamps
        send_tick(make_tick(0, 32767));     // zero error with zero deadband
        wait_idle();

        // Pull the integrator low with no proportional term so the drive clamps at 0
        write_reg(pld_pkg::CFG_PROP_GAIN, 16'h0000);
        write_reg(pld_pkg::CFG_DRIVE_OFFSET, 16'h0000);
        write_reg(pld_pkg::CFG_CENTRE_POS, 16'h0000);
        send_tick(make_tick(50, 32767));
        send_tick(make_tick(-20, 32767));
        send_tick(make_tick(0, 1));
        wait_idle();

        write_reg(pld_pkg::CFG_INTEG_GAIN, 16'h0000);
        write_reg(pld_pkg::CFG_DEADBAND, 16'hFFFF);
        write_reg(pld_pkg::CFG_FULL_POS, 16'hFFFF);
        write_reg(CFG_SPARE_A, 16'hFFFF);
        write_reg(CFG_SPARE_B, 16'h0000);
        send_tick(make_tick(100, 0));       // error equals the widest deadband
        send_tick(make_tick(50, 0));
        send_tick(make_tick(-100, 5));
        wait_idle();
    endtask

    // Random phases: fresh settings each phase, ticks under random or no idling
    task automatic test_random_ticks();
        tick_t t;
        int    live;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_reg(pld_pkg::CFG_PROP_GAIN, pick_reg_value(pld_pkg::GAIN_W, 65535));
            write_reg(pld_pkg::CFG_INTEG_GAIN, pick_reg_value(pld_pkg::GAIN_W, 65535));
            write_reg(pld_pkg::CFG_DEADBAND, pick_reg_value(pld_pkg::POS_W, 400));
            write_reg(pld_pkg::CFG_DRIVE_OFFSET, pick_reg_value(pld_pkg::OFS_W, 4095));
            write_reg(pld_pkg::CFG_CENTRE_POS, pick_reg_value(pld_pkg::POS_W, 32767));
            write_reg(pld_pkg::CFG_FULL_POS, pick_reg_value(pld_pkg::POS_W, 32767));
            write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                      pld_pkg::CFG_DATA_W'($urandom_range(0, 65535)));
            tx_idle_on = ($urandom_range(0, 3) != 0);
            live = 0;
            while (live < TICKS_PER_PHASE)
            begin
                t = random_tick();
                send_tick(t);
                if (t.encoder_count >= 0)
                    live++;
            end
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure, with calm stretches of constant ready
    // ------------------------------------------------------------------------
    initial
    begin : result_stall_gen
        int  stall_left;
        int  mode_left;
        bit  rx_calm;
        stall_left = 0;
        mode_left = 0;
        rx_calm = 1'b0;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                rx_calm = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            if (stall_left > 0)
            begin
                result_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                result_ch.ready = 1'b1;
                if (!rx_calm)
                    stall_left = pick_gap(1'b1);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checker: compare each accepted result with the oldest prediction
    // ------------------------------------------------------------------------
    drive_t want;

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (pending_drives.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: drive_level %0d move_right %0b",
                             result_ch.drive_level, result_ch.move_right);
            end
            else
            begin
                want = pending_drives.pop_front();
                if (result_ch.drive_level !== want.drive_level
                    || result_ch.move_right !== want.move_right)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: drive_level exp %0d got %0d, move_right exp %0b got %0b",
                                 want.drive_level, result_ch.drive_level,
                                 want.move_right, result_ch.move_right);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if nothing moves on either channel for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((tick_ch.valid === 1'b1 && tick_ch.ready === 1'b1)
                || (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("** pi_position_loop_deadband: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset once, run the tests in turn, drain, report
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        cfg_wen = 1'b0;
        cfg_addr = pld_pkg::CFG_PROP_GAIN;
        cfg_data = '0;
        tick_ch.valid = 1'b0;
        tick_ch.command = '0;
        tick_ch.encoder_count = '0;
        tx_idle_on = 1'b1;
        kp_gain = pld_pkg::PROP_GAIN_RST;
        ki_gain = pld_pkg::INTEG_GAIN_RST;
        deadband_lim = pld_pkg::DEADBAND_RST;
        offset_lvl = pld_pkg::DRIVE_OFFSET_RST;
        centre_pos = pld_pkg::CENTRE_POS_RST;
        full_pos = pld_pkg::FULL_POS_RST;
        err_hist = '0;
        integ_acc = '0;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_register_extremes();
        test_random_ticks();

        // wait_idle has drained every prediction; any late extra result is flagged
        wait_idle();
        if (mismatch_count == 0 && pending_drives.size() == 0)
            $display("** pi_position_loop_deadband: PASSED **");
        else
            $display("** pi_position_loop_deadband: FAILED **");
        $finish;
    end

endmodule
